// File: rtl/core/rdfu_pkg.sv
// Shared types and constants for the RDF escape unescaper.
package rdfu_pkg;

  // Input transaction: one raw byte of the escaped string
  typedef struct packed {
    logic [7:0] in_byte;
    logic       byte_is_last;
  } in_t;

  // Output transaction: one unescaped byte or an error report
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
    logic [2:0] error_code;
  } out_t;

  typedef enum logic [1:0] {
    PH_PLAIN   = 2'd0,
    PH_ESCAPE  = 2'd1,
    PH_HEX     = 2'd2,
    PH_DISCARD = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ERR_NONE           = 3'd0,
    ERR_STR_DISALLOWED = 3'd1,
    ERR_NUM_DISALLOWED = 3'd2,
    ERR_UNKNOWN        = 3'd3,
    ERR_TRUNCATED      = 3'd4,
    ERR_BAD_HEX        = 3'd5
  } err_e;

  // Escape mode register codes; the unused code behaves as MODE_NL_BS
  localparam logic [1:0] MODE_ALL     = 2'd0;
  localparam logic [1:0] MODE_NUMERIC = 2'd1;
  localparam logic [1:0] MODE_NL_BS   = 2'd2;

  // Characters recognised by the parser
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_U_LO      = 8'h75;
  localparam logic [7:0] CH_U_UP      = 8'h55;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;

  // Bytes produced by the single-character escapes
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_FF  = 8'h0C;

  localparam logic [3:0] HEX_LEN_SHORT = 4'd4;
  localparam logic [3:0] HEX_LEN_LONG  = 4'd8;

  localparam logic [31:0] CP_MAX      = 32'h0010_FFFF;
  localparam logic [31:0] CP_SURR_LO  = 32'h0000_D800;
  localparam logic [31:0] CP_SURR_HI  = 32'h0000_DFFF;

  // Group of up to four results caused by one input byte
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            str_end;
    err_e            err;
  } grp_t;

endpackage

// File: rtl/core/rdfu_parser.sv
// Escape parser: parse state and the decode of one byte into a result group.
module rdfu_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  rdfu_pkg::in_t in_data_i,
  input  logic [1:0]    mode_i,
  output rdfu_pkg::grp_t grp_o,
  output logic          has_res_o
);

  rdfu_pkg::phase_e phase_q, phase_d;
  logic [3:0]       left_q, left_d;
  logic [31:0]      acc_q, acc_d;

  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  logic        last;
  logic [7:0]  b;
  logic        all_ok, numeric_ok, nl_bs_ok;
  logic [4:0]  hd;
  logic [31:0] acc_new;
  logic        cp_bad;
  logic        err_hit;
  rdfu_pkg::err_e err_code;

  assign last       = in_data_i.byte_is_last;
  assign b          = in_data_i.in_byte;
  assign all_ok     = (mode_i == rdfu_pkg::MODE_ALL);
  assign numeric_ok = (mode_i == rdfu_pkg::MODE_ALL) || (mode_i == rdfu_pkg::MODE_NUMERIC);
  assign nl_bs_ok   = (mode_i != rdfu_pkg::MODE_NUMERIC);
  assign hd         = hex_digit(b);
  assign acc_new    = {acc_q[27:0], hd[3:0]};
  assign cp_bad     = (acc_new > rdfu_pkg::CP_MAX) ||
                      ((acc_new >= rdfu_pkg::CP_SURR_LO) && (acc_new <= rdfu_pkg::CP_SURR_HI));

  always_comb begin
    phase_d   = phase_q;
    left_d    = left_q;
    acc_d     = acc_q;
    has_res_o = 1'b0;
    err_hit   = 1'b0;
    err_code  = rdfu_pkg::ERR_NONE;
    grp_o     = '0;
    grp_o.str_end = last;
    grp_o.err     = rdfu_pkg::ERR_NONE;

    unique case (phase_q)
      rdfu_pkg::PH_PLAIN: begin
        if (b == rdfu_pkg::CH_BACKSLASH) begin
          if (last) begin
            err_hit  = 1'b1;
            err_code = rdfu_pkg::ERR_TRUNCATED;
          end else begin
            phase_d = rdfu_pkg::PH_ESCAPE;
          end
        end else begin
          has_res_o      = 1'b1;
          grp_o.bytes[0] = b;
        end
      end

      rdfu_pkg::PH_ESCAPE: begin
        phase_d   = rdfu_pkg::PH_PLAIN;
        has_res_o = 1'b1;
        unique case (b)
          rdfu_pkg::CH_T:       grp_o.bytes[0] = rdfu_pkg::BYTE_TAB;
          rdfu_pkg::CH_R:       grp_o.bytes[0] = rdfu_pkg::BYTE_CR;
          rdfu_pkg::CH_B:       grp_o.bytes[0] = rdfu_pkg::BYTE_BS;
          rdfu_pkg::CH_F:       grp_o.bytes[0] = rdfu_pkg::BYTE_FF;
          rdfu_pkg::CH_DQUOTE,
          rdfu_pkg::CH_SQUOTE,
          rdfu_pkg::CH_BACKSLASH: grp_o.bytes[0] = b;
          rdfu_pkg::CH_N:       grp_o.bytes[0] = rdfu_pkg::BYTE_LF;
          default:              grp_o.bytes[0] = 8'h00;
        endcase
        unique case (b)
          rdfu_pkg::CH_T, rdfu_pkg::CH_R, rdfu_pkg::CH_B, rdfu_pkg::CH_F,
          rdfu_pkg::CH_DQUOTE, rdfu_pkg::CH_SQUOTE: begin
            if (!all_ok) begin
              err_hit  = 1'b1;
              err_code = rdfu_pkg::ERR_STR_DISALLOWED;
            end
          end
          rdfu_pkg::CH_N, rdfu_pkg::CH_BACKSLASH: begin
            if (!nl_bs_ok) begin
              err_hit  = 1'b1;
              err_code = rdfu_pkg::ERR_STR_DISALLOWED;
            end
          end
          rdfu_pkg::CH_U_LO, rdfu_pkg::CH_U_UP: begin
            has_res_o = 1'b0;
            if (!numeric_ok) begin
              err_hit  = 1'b1;
              err_code = rdfu_pkg::ERR_NUM_DISALLOWED;
            end else if (last) begin
              err_hit  = 1'b1;
              err_code = rdfu_pkg::ERR_TRUNCATED;
            end else begin
              phase_d = rdfu_pkg::PH_HEX;
              left_d  = (b == rdfu_pkg::CH_U_LO) ? rdfu_pkg::HEX_LEN_SHORT
                                                 : rdfu_pkg::HEX_LEN_LONG;
              acc_d   = '0;
            end
          end
          default: begin
            err_hit  = 1'b1;
            err_code = rdfu_pkg::ERR_UNKNOWN;
          end
        endcase
      end

      rdfu_pkg::PH_HEX: begin
        if (last && (left_q > 4'd1)) begin
          err_hit  = 1'b1;
          err_code = rdfu_pkg::ERR_TRUNCATED;
        end else if (!hd[4]) begin
          err_hit  = 1'b1;
          err_code = rdfu_pkg::ERR_BAD_HEX;
        end else if (left_q <= 4'd1) begin
          phase_d = rdfu_pkg::PH_PLAIN;
          left_d  = '0;
          acc_d   = '0;
          if (cp_bad) begin
            err_hit  = 1'b1;
            err_code = rdfu_pkg::ERR_BAD_HEX;
          end else begin
            has_res_o = 1'b1;
            // UTF-8 encode: one to four bytes depending on magnitude
            if (acc_new < 32'h80) begin
              grp_o.bytes[0] = acc_new[7:0];
              grp_o.last_idx = 2'd0;
            end else if (acc_new < 32'h800) begin
              grp_o.bytes[0] = {3'b110, acc_new[10:6]};
              grp_o.bytes[1] = {2'b10, acc_new[5:0]};
              grp_o.last_idx = 2'd1;
            end else if (acc_new < 32'h1_0000) begin
              grp_o.bytes[0] = {4'b1110, acc_new[15:12]};
              grp_o.bytes[1] = {2'b10, acc_new[11:6]};
              grp_o.bytes[2] = {2'b10, acc_new[5:0]};
              grp_o.last_idx = 2'd2;
            end else begin
              grp_o.bytes[0] = {5'b11110, acc_new[20:18]};
              grp_o.bytes[1] = {2'b10, acc_new[17:12]};
              grp_o.bytes[2] = {2'b10, acc_new[11:6]};
              grp_o.bytes[3] = {2'b10, acc_new[5:0]};
              grp_o.last_idx = 2'd3;
            end
          end
        end else begin
          left_d = left_q - 4'd1;
          acc_d  = acc_new;
        end
      end

      rdfu_pkg::PH_DISCARD: begin
        if (last) begin
          phase_d = rdfu_pkg::PH_PLAIN;
        end
      end
    endcase

    // Any fault reports once and drops the rest of the string
    if (err_hit) begin
      has_res_o      = 1'b1;
      grp_o          = '0;
      grp_o.str_end  = 1'b1;
      grp_o.err      = err_code;
      phase_d        = last ? rdfu_pkg::PH_PLAIN : rdfu_pkg::PH_DISCARD;
      left_d         = '0;
      acc_d          = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rdfu_pkg::PH_PLAIN;
      left_q  <= '0;
      acc_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      acc_q   <= acc_d;
    end
  end

endmodule

// File: rtl/core/rdfu_out_queue.sv
// Result register: holds one result group and hands it out byte by byte.
module rdfu_out_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  rdfu_pkg::grp_t  grp_i,
  output logic            can_load_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rdfu_pkg::out_t  out_data_o
);

  logic           valid_q;
  rdfu_pkg::grp_t grp_q;
  logic [1:0]     idx_q;
  logic           at_last;
  logic           out_fire;

  assign at_last    = (idx_q == grp_q.last_idx);
  assign out_fire   = valid_q && out_ready_i;
  assign can_load_o = !valid_q || (out_fire && at_last);

  assign out_valid_o           = valid_q;
  assign out_data_o.out_byte   = grp_q.bytes[idx_q];
  assign out_data_o.run_last   = at_last;
  assign out_data_o.string_end = at_last && grp_q.str_end;
  assign out_data_o.error_code = grp_q.err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (out_fire) begin
      if (at_last) begin
        valid_q <= 1'b0;
      end
      idx_q <= idx_q + 2'd1;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_i;
    end
  end

endmodule

// File: rtl/core/rdf_escape_unescaper.sv
// Top level of the streaming RDF string unescaper.
//
//  channel | direction | payload              | transaction when
//  --------+-----------+----------------------+------------------------------
//  in      | sink      | in_t  (byte, last)   | in_valid_i  && in_ready_o
//  out     | source    | out_t (byte, flags)  | out_valid_o && out_ready_i
//  cfg     | sink      | escape_mode (2 bits) | cfg_valid_i && cfg_ready_o
//
// Each input byte is decoded combinationally and its results (none to four)
// are loaded into the result register at the accepting edge; the first of
// them is offered in the next cycle.
// One transaction per cycle on both sides while out_ready_i is held high and
// each byte gives at most one result; a numeric escape that expands to N UTF-8
// bytes stalls the input while the result register drains.
// Reset (rst_ni low, asynchronous) returns the parser to plain text and
// clears the escape mode to all escapes allowed. No clearing pass.
// Stalls: a full result register holds the input until its last byte is
// taken; the input is released in the same cycle that last byte goes.
module rdf_escape_unescaper (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rdfu_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rdfu_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_data_i
);

  logic           in_fire;
  logic           has_res;
  logic           can_load;
  rdfu_pkg::grp_t grp;
  logic [1:0]     mode_q;

  // Configuration is to be written only while idle; the user keeps to this, unchecked here, so always take it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rdfu_pkg::MODE_ALL;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // Accept whenever the result register is free or freeing this cycle;
  // bytes that give no result still wait here so ordering stays simple.
  assign in_ready_o = can_load;
  assign in_fire    = in_valid_i && in_ready_o;

  rdfu_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (in_fire),
    .in_data_i (in_data_i),
    .mode_i    (mode_q),
    .grp_o     (grp),
    .has_res_o (has_res)
  );

  // Load the result group only for bytes that cause output
  rdfu_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_fire && has_res),
    .grp_i       (grp),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
